/* rtl/pcri_pkg.sv */
// Package for the video processor CPU register file: item types, command and
// register codes, memory request structs and address mapping helpers.
// No dependencies.
package pcri_pkg;

    localparam int PATTERN_BYTES   = 8192;
    localparam int NAMETABLE_BYTES = 2048;
    localparam int OAM_BYTES       = 256;
    localparam int PALETTE_BYTES   = 32;

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int OAM_AW = $clog2(OAM_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);
    localparam int BUS_AW = 14;

    // Command codes.
    localparam logic [2:0] CMD_CPU_READ   = 3'd0;
    localparam logic [2:0] CMD_CPU_WRITE  = 3'd1;
    localparam logic [2:0] CMD_ROM_LOAD   = 3'd2;
    localparam logic [2:0] CMD_VBLANK_SET = 3'd3;
    localparam logic [2:0] CMD_PRERENDER  = 3'd4;

    // CPU register numbers.
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [7:0] PAL_GRAY_MASK  = 8'h30;
    localparam logic [7:0] PAL_COLOR_MASK = 8'h3F;
    localparam logic [5:0] PAL_PAGE       = 6'h3F;

    // Configuration register index.
    localparam logic CFG_MIRRORING = 1'b0;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [2:0]        reg_index;
        logic [7:0]        write_byte;
        logic [PAT_AW-1:0] rom_address;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       nmi_request;
    } t_out_item;

    typedef enum logic [1:0] {
        RGN_PATTERN,
        RGN_NAMETABLE,
        RGN_PALETTE
    } t_region;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [BUS_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BUS_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rom_wr_en;
        logic [PAT_AW-1:0] rom_wr_addr;
    } t_vram_req;

    typedef struct packed {
        logic              rd_en;
        logic [OAM_AW-1:0] rd_addr;
        logic              wr_en;
        logic [OAM_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
    } t_oam_req;

    function automatic t_region addr_region(input logic [BUS_AW-1:0] addr);
        t_region rgn;
        if (!addr[13]) begin
            rgn = RGN_PATTERN;
        end else if (addr[13:8] == PAL_PAGE) begin
            rgn = RGN_PALETTE;
        end else begin
            rgn = RGN_NAMETABLE;
        end
        return rgn;
    endfunction

    // Quadrant bits 11:10 pick one of two banks, by low or high bit.
    function automatic logic [NT_AW-1:0] nt_bank_addr(input logic mode,
                                                      input logic [BUS_AW-1:0] addr);
        logic bank;
        bank = mode ? addr[11] : addr[10];
        return {bank, addr[NT_AW-2:0]};
    endfunction

    // Backdrop entries of the sprite half alias the background half.
    function automatic logic [PAL_AW-1:0] pal_index(input logic [BUS_AW-1:0] addr);
        logic [PAL_AW-1:0] idx;
        idx = addr[PAL_AW-1:0];
        if (idx[1:0] == 2'b00) begin
            idx[4] = 1'b0;
        end
        return idx;
    endfunction

endpackage

/* rtl/pcri_vram.sv */
// Video memory behind the data port: pattern ROM, mirrored nametable RAM and
// palette RAM, each with a registered read. Depends on pcri_pkg.
module pcri_vram
    import pcri_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_mirroring,
    input  t_vram_req i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_pattern [PATTERN_BYTES];
    logic [7:0] r_nametable [NAMETABLE_BYTES];
    logic [7:0] r_palette [PALETTE_BYTES];

    logic [7:0] r_pat_q;
    logic [7:0] r_nt_q;
    logic [7:0] r_pal_q;
    t_region    r_rd_region;

    t_region rd_region;
    t_region wr_region;

    assign rd_region = addr_region(i_req.rd_addr);
    assign wr_region = addr_region(i_req.wr_addr);

    always_ff @(posedge i_clk) begin
        if (i_req.rom_wr_en) begin
            r_pattern[i_req.rom_wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_pat_q <= r_pattern[i_req.rd_addr[PAT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en && wr_region == RGN_NAMETABLE) begin
            r_nametable[nt_bank_addr(i_mirroring, i_req.wr_addr)] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_nt_q <= r_nametable[nt_bank_addr(i_mirroring, i_req.rd_addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_BYTES; i++) begin
                r_palette[i] <= 8'h00;
            end
            r_rd_region <= RGN_PATTERN;
        end else begin
            if (i_req.wr_en && wr_region == RGN_PALETTE) begin
                r_palette[pal_index(i_req.wr_addr)] <= i_req.wr_data;
            end
            if (i_req.rd_en) begin
                r_rd_region <= rd_region;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_pal_q <= r_palette[pal_index(i_req.rd_addr)];
        end
    end

    always_comb begin
        unique case (r_rd_region)
            RGN_PATTERN:   o_rd_data = r_pat_q;
            RGN_NAMETABLE: o_rd_data = r_nt_q;
            RGN_PALETTE:   o_rd_data = r_pal_q;
            default:       o_rd_data = 8'h00;
        endcase
    end

endmodule

/* rtl/pcri_oam.sv */
// Sprite attribute memory with one valid bit per entry, so that entries
// never written read as zero after reset. Depends on pcri_pkg.
module pcri_oam
    import pcri_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_oam_req   i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0]           r_mem [OAM_BYTES];
    logic [OAM_BYTES-1:0] r_valid;
    logic [7:0]           r_rd_q;
    logic                 r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_q : 8'h00;

endmodule

/* rtl/ppu_cpu_register_interface.sv */
// CPU register file of a tile video processor. Depends on pcri_pkg, pcri_vram, pcri_oam.
// Each request is accepted in the idle state, where its memory reads are issued, and
// completes in the update state that uses them, which registers its result; a result
// not yet taken holds the update state, and no new request is taken until it ends.
// Reset: registers clear, vblank sets, palette clears, OAM entries read as zero;
// nametable and pattern ROM stay undefined until written.
module ppu_cpu_register_interface
    import pcri_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_state    r_state, n_state;
    t_in_item  r_item;
    t_out_item r_out, n_out;
    logic      r_out_valid;

    logic        r_mirroring;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_mask, n_mask;
    logic        r_vblank, n_vblank;
    logic [7:0]  r_oam_ptr, n_oam_ptr;
    logic [14:0] r_v, n_v;
    logic [14:0] r_t, n_t;
    logic [2:0]  r_fine_x, n_fine_x;
    logic        r_latch, n_latch;
    logic [7:0]  r_rd_buf, n_rd_buf;

    logic        accept;
    logic        exec_fire;
    t_vram_req   vram_req;
    t_oam_req    oam_req;
    logic [7:0]  vram_rd;
    logic [7:0]  oam_rd;
    logic [7:0]  bus_byte;
    logic        v_is_pal;
    logic [14:0] v_step;
    logic [14:0] v_next;

    pcri_vram u_vram (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mirroring (r_mirroring),
        .i_req       (vram_req),
        .o_rd_data   (vram_rd)
    );

    pcri_oam u_oam (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (oam_req),
        .o_rd_data (oam_rd)
    );

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_MIRRORING) ? {31'd0, r_mirroring} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == CFG_MIRRORING) begin
            r_mirroring <= pwdata[0];
        end
    end

    // Sequencer: accept, then update once the output register is free.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_EXEC;
            ST_EXEC: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_EXEC: exec_fire  = !r_out_valid || i_out_ready;
            default: o_in_ready = 1'b0;
        endcase
    end

    assign accept   = i_in_valid && o_in_ready;
    assign v_is_pal = (addr_region(r_v[BUS_AW-1:0]) == RGN_PALETTE);
    assign v_step   = r_ctrl[2] ? 15'd32 : 15'd1;
    assign v_next   = r_v + v_step;
    assign bus_byte = v_is_pal
                    ? (vram_rd & (r_mask[0] ? PAL_GRAY_MASK : PAL_COLOR_MASK))
                    : vram_rd;

    always_comb begin
        n_ctrl    = r_ctrl;
        n_mask    = r_mask;
        n_vblank  = r_vblank;
        n_oam_ptr = r_oam_ptr;
        n_v       = r_v;
        n_t       = r_t;
        n_fine_x  = r_fine_x;
        n_latch   = r_latch;
        n_rd_buf  = r_rd_buf;
        n_out     = '0;

        // Reads are issued at accept; the state they address is unchanged
        // until the update cycle.
        vram_req.rd_en       = accept;
        vram_req.rd_addr     = r_v[BUS_AW-1:0];
        vram_req.wr_en       = 1'b0;
        vram_req.wr_addr     = r_v[BUS_AW-1:0];
        vram_req.wr_data     = r_item.write_byte;
        vram_req.rom_wr_en   = 1'b0;
        vram_req.rom_wr_addr = r_item.rom_address;
        oam_req.rd_en        = accept;
        oam_req.rd_addr      = r_oam_ptr;
        oam_req.wr_en        = 1'b0;
        oam_req.wr_addr      = r_oam_ptr;
        oam_req.wr_data      = r_item.write_byte;

        if (exec_fire) begin
            case (r_item.cmd)
                CMD_CPU_READ: begin
                    case (r_item.reg_index)
                        REG_STATUS: begin
                            n_out.read_byte = {r_vblank, 2'b00, r_rd_buf[4:0]};
                            n_vblank = 1'b0;
                            n_latch  = 1'b0;
                        end
                        REG_OAM_DATA: n_out.read_byte = oam_rd;
                        REG_DATA: begin
                            n_out.read_byte = v_is_pal ? bus_byte : r_rd_buf;
                            n_rd_buf = bus_byte;
                            n_v      = v_next;
                        end
                        default: n_out.read_byte = 8'h00;
                    endcase
                end
                CMD_CPU_WRITE: begin
                    case (r_item.reg_index)
                        REG_CTRL: begin
                            n_ctrl       = r_item.write_byte;
                            n_t[11:10]   = r_item.write_byte[1:0];
                        end
                        REG_MASK:     n_mask    = r_item.write_byte;
                        REG_OAM_ADDR: n_oam_ptr = r_item.write_byte;
                        REG_OAM_DATA: oam_req.wr_en = 1'b1;
                        REG_SCROLL: begin
                            if (!r_latch) begin
                                n_fine_x = r_item.write_byte[2:0];
                                n_t[4:0] = r_item.write_byte[7:3];
                            end else begin
                                n_t[14:12] = r_item.write_byte[2:0];
                                n_t[9:5]   = r_item.write_byte[7:3];
                            end
                            n_latch = !r_latch;
                        end
                        REG_ADDR: begin
                            if (!r_latch) begin
                                n_t[14]   = 1'b0;
                                n_t[13:8] = r_item.write_byte[5:0];
                            end else begin
                                n_t[7:0] = r_item.write_byte;
                                n_v      = {r_t[14:8], r_item.write_byte};
                            end
                            n_latch = !r_latch;
                        end
                        REG_DATA: begin
                            // Pattern ROM writes are dropped inside the memory unit.
                            vram_req.wr_en = 1'b1;
                            n_v            = v_next;
                        end
                        default: n_ctrl = r_ctrl;
                    endcase
                end
                CMD_ROM_LOAD: vram_req.rom_wr_en = 1'b1;
                CMD_VBLANK_SET: begin
                    n_vblank          = 1'b1;
                    n_out.nmi_request = r_ctrl[7];
                end
                CMD_PRERENDER: n_vblank = 1'b0;
                default: n_vblank = r_vblank;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ctrl      <= 8'h00;
            r_mask      <= 8'h00;
            r_vblank    <= 1'b1;
            r_oam_ptr   <= 8'h00;
            r_v         <= 15'd0;
            r_t         <= 15'd0;
            r_fine_x    <= 3'd0;
            r_latch     <= 1'b0;
            r_rd_buf    <= 8'h00;
        end else begin
            r_state   <= n_state;
            r_ctrl    <= n_ctrl;
            r_mask    <= n_mask;
            r_vblank  <= n_vblank;
            r_oam_ptr <= n_oam_ptr;
            r_v       <= n_v;
            r_t       <= n_t;
            r_fine_x  <= n_fine_x;
            r_latch   <= n_latch;
            r_rd_buf  <= n_rd_buf;
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_data;
        end
        if (exec_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter the update cycle");

    a_exec_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_fire |=> o_out_valid)
        else $error("completed request left no result");

    a_nmi_with_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.nmi_request) |-> r_vblank)
        else $error("nmi result pending while vblank is clear");

    a_status_clears_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_fire && r_item.cmd == CMD_CPU_READ && r_item.reg_index == REG_STATUS)
        |=> (!r_latch && !r_vblank))
        else $error("status read did not clear latch and vblank");
`endif

endmodule

/* bench/ppu_reg_file_checker.sv */
`timescale 1ns / 100ps
// Checker for the video processor CPU register file. It watches the request,
// result and APB channels, predicts each result from its own copy of the state
// and compares it with what the block returns. Depends on pcri_pkg.
module ppu_reg_file_checker
    import pcri_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  t_in_item    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  t_out_item   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          pending_results,
    output int          mismatch_count
);
    localparam logic [2:0] MIRROR_ADDR = {CFG_MIRRORING, 2'b00};

    logic        mirror_sel;
    logic [7:0]  ctrl_reg;
    logic [7:0]  mask_reg;
    logic [7:0]  oam_ptr;
    logic [7:0]  data_buf;
    logic        vblank;
    logic        addr_latch;
    logic [14:0] vram_addr;
    logic [14:0] temp_addr;
    logic [2:0]  fine_x;
    logic [7:0]  nt_mem  [NAMETABLE_BYTES];
    logic [7:0]  pal_mem [PALETTE_BYTES];
    logic [7:0]  oam_mem [OAM_BYTES];
    logic [7:0]  rom_mem [PATTERN_BYTES];
    t_out_item   expected_results[$];

    function automatic logic [NT_AW-1:0] nt_slot(input logic [13:0] addr);
        logic [1:0] quadrant;
        logic       bank;
        quadrant = addr[11:10];
        bank = mirror_sel ? quadrant[1] : quadrant[0];
        return {bank, addr[9:0]};
    endfunction

    function automatic logic [PAL_AW-1:0] pal_slot(input logic [13:0] addr);
        logic [4:0] idx;
        idx = addr[4:0];
        // The backdrop entries of the sprite half share storage with the background half.
        if (idx[1:0] == 2'b00 && idx[4]) begin
            idx = idx & 5'h0F;
        end
        return idx;
    endfunction

    function automatic logic [7:0] vram_fetch(input logic [13:0] addr);
        if (addr < 14'h2000) begin
            return rom_mem[addr[PAT_AW-1:0]];
        end
        if (addr < 14'h3F00) begin
            return nt_mem[nt_slot(addr)];
        end
        return pal_mem[pal_slot(addr)] & (mask_reg[0] ? PAL_GRAY_MASK : PAL_COLOR_MASK);
    endfunction

    function automatic void vram_store(input logic [13:0] addr, input logic [7:0] data);
        if (addr < 14'h2000) begin
            return;
        end
        if (addr < 14'h3F00) begin
            nt_mem[nt_slot(addr)] = data;
        end else begin
            pal_mem[pal_slot(addr)] = data;
        end
    endfunction

    function automatic void advance_vram_addr();
        vram_addr = vram_addr + (ctrl_reg[2] ? 15'd32 : 15'd1);
    endfunction

    function automatic void clear_state();
        mirror_sel = 1'b0;
        ctrl_reg   = '0;
        mask_reg   = '0;
        vblank     = 1'b1;
        oam_ptr    = '0;
        vram_addr  = '0;
        temp_addr  = '0;
        fine_x     = '0;
        addr_latch = 1'b0;
        data_buf   = '0;
        foreach (nt_mem[i]) nt_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        foreach (oam_mem[i]) oam_mem[i] = '0;
        foreach (rom_mem[i]) rom_mem[i] = '0;
    endfunction

    function automatic t_out_item predict_result(input t_in_item req);
        t_out_item   res;
        logic [13:0] addr;
        logic [7:0]  d;
        res  = '0;
        d    = req.write_byte;
        addr = vram_addr[13:0];
        case (req.cmd)
            CMD_CPU_READ: begin
                case (req.reg_index)
                    REG_STATUS: begin
                        // Overflow and sprite-zero bits always read low.
                        res.read_byte = {vblank, 2'b00, data_buf[4:0]};
                        vblank = 1'b0;
                        addr_latch = 1'b0;
                    end
                    REG_OAM_DATA: res.read_byte = oam_mem[oam_ptr];
                    REG_DATA: begin
                        res.read_byte = data_buf;
                        data_buf = vram_fetch(addr);
                        if (addr >= 14'h3F00) begin
                            res.read_byte = data_buf;
                        end
                        advance_vram_addr();
                    end
                    default: ;
                endcase
            end
            CMD_CPU_WRITE: begin
                case (req.reg_index)
                    REG_CTRL: begin
                        ctrl_reg = d;
                        temp_addr[11:10] = d[1:0];
                    end
                    REG_MASK:     mask_reg = d;
                    REG_OAM_ADDR: oam_ptr = d;
                    REG_OAM_DATA: oam_mem[oam_ptr] = d;
                    REG_SCROLL: begin
                        if (!addr_latch) begin
                            fine_x = d[2:0];
                            temp_addr[4:0] = d[7:3];
                        end else begin
                            temp_addr[14:12] = d[2:0];
                            temp_addr[9:5] = d[7:3];
                        end
                        addr_latch = !addr_latch;
                    end
                    REG_ADDR: begin
                        if (!addr_latch) begin
                            temp_addr = {1'b0, d[5:0], temp_addr[7:0]};
                        end else begin
                            temp_addr[7:0] = d;
                            vram_addr = temp_addr;
                        end
                        addr_latch = !addr_latch;
                    end
                    REG_DATA: begin
                        vram_store(addr, d);
                        advance_vram_addr();
                    end
                    default: ;
                endcase
            end
            CMD_ROM_LOAD: rom_mem[req.rom_address] = d;
            CMD_VBLANK_SET: begin
                vblank = 1'b1;
                res.nmi_request = ctrl_reg[7];
            end
            CMD_PRERENDER: vblank = 1'b0;
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            clear_state();
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (psel && penable && pready && paddr == MIRROR_ADDR) begin
                if (pwrite) begin
                    mirror_sel = pwdata[0];
                end else if (prdata !== {31'b0, mirror_sel}) begin
                    $display("%0t: mirroring readback expected %08h actual %08h",
                             $time, {31'b0, mirror_sel}, prdata);
                    mismatch_count++;
                end
            end
            if (in_valid && in_ready) begin
                expected_results.push_back(predict_result(in_item));
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result expected none actual read_byte %02h nmi %0b",
                             $time, out_item.read_byte, out_item.nmi_request);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.read_byte !== want.read_byte) begin
                        $display("%0t: read_byte expected %02h actual %02h",
                                 $time, want.read_byte, out_item.read_byte);
                        mismatch_count++;
                    end
                    if (out_item.nmi_request !== want.nmi_request) begin
                        $display("%0t: nmi_request expected %0b actual %0b",
                                 $time, want.nmi_request, out_item.nmi_request);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_results = expected_results.size();
    end

endmodule

/* bench/ppu_cpu_register_interface_tb.sv */
`timescale 1ns / 100ps
// Top of the regression for ppu_cpu_register_interface: clock, reset, request and
// APB stimulus and the verdict. Depends on it, pcri_pkg and ppu_reg_file_checker.
module ppu_cpu_register_interface_tb;
    import pcri_pkg::*;

    localparam int         RANDOM_REQUESTS = 1472;
    localparam int         PHASE_COUNT     = 8;
    localparam int         FILL_BYTES      = 128;
    localparam int         START_SPAN      = 32;
    localparam int         MAX_DATA_RUN    = 4;
    localparam logic [2:0] MIRROR_ADDR     = {CFG_MIRRORING, 2'b00};
    localparam logic [2:0] CMD_LAST_CODE   = 3'd7;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    int          send_gap_pct   = 0;
    int          recv_stall_pct = 0;
    int          request_count  = 0;
    int          pending_results;
    int          mismatch_count;

    ppu_cpu_register_interface dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    ppu_reg_file_checker reg_file_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pending_results(pending_results),
        .mismatch_count (mismatch_count)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic t_in_item noise_request();
        t_in_item req;
        req.cmd         = 3'($urandom_range(7));
        req.reg_index   = 3'($urandom_range(7));
        req.write_byte  = rand_byte();
        req.rom_address = PAT_AW'($urandom_range(PATTERN_BYTES - 1));
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so a following request keeps it up without a glitch.
    task automatic issue_request(input t_in_item req);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        request_count++;
    endtask

    // Unused fields carry random values; the block must ignore them.
    task automatic send_op(input logic [2:0] cmd, input logic [2:0] reg_num,
                           input logic [7:0] data);
        t_in_item req;
        req            = noise_request();
        req.cmd        = cmd;
        req.reg_index  = reg_num;
        req.write_byte = data;
        issue_request(req);
    endtask

    task automatic load_pattern(input logic [PAT_AW-1:0] addr, input logic [7:0] data);
        t_in_item req;
        req             = noise_request();
        req.cmd         = CMD_ROM_LOAD;
        req.write_byte  = data;
        req.rom_address = addr;
        issue_request(req);
    endtask

    task automatic apb_transfer(input logic is_write, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= MIRROR_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The register may only change while the block is idle.
    task automatic set_mirroring(input logic mode);
        logic [31:0] word;
        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        word = $urandom;
        word[0] = mode;
        apb_transfer(1'b1, word);
        apb_transfer(1'b0, '0);
    endtask

    task automatic random_burst();
        int         pick;
        int         region;
        logic [7:0] hi;
        logic [7:0] lo;
        t_in_item   req;
        pick = $urandom_range(99);
        if (pick < 35) begin
            // Point v somewhere, then run a short string of data port accesses.
            // The status read makes the address pair start on its first write.
            // Outside the palette, a start below START_SPAN and at most three
            // steps of 32 keep every read inside the filled windows.
            send_op(CMD_CPU_READ, REG_STATUS, rand_byte());
            region = $urandom_range(2);
            case (region)
                0: hi = {2'($urandom_range(3)), 6'h3F};
                1: hi = {2'($urandom_range(3)), 2'b10, 2'($urandom_range(3)), 2'b00};
                default: hi = {2'($urandom_range(3)), 6'h00};
            endcase
            lo = (region == 0) ? rand_byte() : 8'($urandom_range(START_SPAN - 1));
            send_op(CMD_CPU_WRITE, REG_ADDR, hi);
            send_op(CMD_CPU_WRITE, REG_ADDR, lo);
            repeat ($urandom_range(1, MAX_DATA_RUN)) begin
                send_op($urandom_range(1) ? CMD_CPU_READ : CMD_CPU_WRITE, REG_DATA,
                        rand_byte());
            end
        end else if (pick < 45) begin
            send_op(CMD_CPU_WRITE, REG_SCROLL, rand_byte());
            send_op(CMD_CPU_WRITE, REG_SCROLL, rand_byte());
        end else if (pick < 55) begin
            send_op(CMD_CPU_WRITE, REG_OAM_ADDR, rand_byte());
            repeat ($urandom_range(1, 3)) begin
                send_op($urandom_range(1) ? CMD_CPU_READ : CMD_CPU_WRITE, REG_OAM_DATA,
                        rand_byte());
            end
        end else if (pick < 65) begin
            send_op(CMD_CPU_WRITE, $urandom_range(1) ? REG_CTRL : REG_MASK, rand_byte());
        end else if (pick < 72) begin
            send_op(CMD_CPU_READ, REG_STATUS, rand_byte());
        end else if (pick < 80) begin
            send_op($urandom_range(1) ? CMD_VBLANK_SET : CMD_PRERENDER, 3'($urandom_range(7)),
                    rand_byte());
        end else if (pick < 88) begin
            load_pattern(PAT_AW'($urandom_range(PATTERN_BYTES - 1)), rand_byte());
        end else begin
            req = noise_request();
            // A data port read at an arbitrary v could land on an unwritten entry.
            if (req.cmd == CMD_CPU_READ && req.reg_index == REG_DATA) begin
                req.cmd = CMD_CPU_WRITE;
            end
            issue_request(req);
        end
    endtask

    initial begin
        int first;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        set_mirroring(1'b0);

        // State straight out of reset: vblank set, OAM clear.
        send_op(CMD_CPU_READ, REG_STATUS, rand_byte());
        send_op(CMD_CPU_READ, REG_OAM_DATA, rand_byte());

        // Fill a window at the bottom of pattern ROM and of both nametable banks.
        // Quadrant 0 uses bank 0 and quadrant 3 bank 1 under either mirroring.
        for (int i = 0; i < FILL_BYTES; i++) begin
            load_pattern(PAT_AW'(i), rand_byte());
        end
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h20);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h00);
        for (int i = 0; i < FILL_BYTES; i++) begin
            send_op(CMD_CPU_WRITE, REG_DATA, rand_byte());
        end
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h2C);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h00);
        for (int i = 0; i < FILL_BYTES; i++) begin
            send_op(CMD_CPU_WRITE, REG_DATA, rand_byte());
        end

        // NMI follows the enable bit on every vblank start, also when repeated.
        send_op(CMD_CPU_WRITE, REG_CTRL, 8'h80);
        send_op(CMD_VBLANK_SET, REG_CTRL, 8'h00);
        send_op(CMD_VBLANK_SET, REG_DATA, 8'hFF);
        send_op(CMD_CPU_READ, REG_STATUS, 8'h00);
        send_op(CMD_CPU_READ, REG_STATUS, 8'hFF);
        send_op(CMD_PRERENDER, REG_STATUS, 8'hFF);
        send_op(CMD_CPU_WRITE, REG_STATUS, 8'hFF);
        // Write-only registers read back as zero.
        send_op(CMD_CPU_READ, REG_CTRL, 8'hFF);
        send_op(CMD_CPU_READ, REG_MASK, 8'hFF);
        send_op(CMD_CPU_READ, REG_OAM_ADDR, 8'hFF);
        send_op(CMD_CPU_READ, REG_SCROLL, 8'hFF);
        send_op(CMD_CPU_READ, REG_ADDR, 8'hFF);
        // Sprite backdrop mirror, then a grayscale palette read.
        send_op(CMD_CPU_WRITE, REG_MASK, 8'h01);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h3F);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h10);
        send_op(CMD_CPU_WRITE, REG_DATA, 8'hFF);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h3F);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h00);
        send_op(CMD_CPU_READ, REG_DATA, 8'h00);
        // A data write into pattern ROM is dropped while v still moves on.
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'h1F);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'hFF);
        send_op(CMD_CPU_WRITE, REG_DATA, 8'h5A);
        send_op(CMD_CPU_READ, REG_DATA, 8'h00);
        send_op(CMD_CPU_WRITE, REG_OAM_ADDR, 8'hFF);
        send_op(CMD_CPU_WRITE, REG_OAM_DATA, 8'hA5);
        send_op(CMD_CPU_READ, REG_OAM_DATA, 8'h00);
        send_op(CMD_CPU_WRITE, REG_SCROLL, 8'h00);
        send_op(CMD_CPU_WRITE, REG_SCROLL, 8'hFF);
        // Top of the address space with step 32 carries v into bit 14, so the bus address wraps.
        send_op(CMD_CPU_WRITE, REG_CTRL, 8'h04);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'hFF);
        send_op(CMD_CPU_WRITE, REG_ADDR, 8'hFF);
        send_op(CMD_CPU_READ, REG_DATA, 8'h00);
        send_op(CMD_CPU_READ, REG_DATA, 8'hFF);
        load_pattern(PAT_AW'(PATTERN_BYTES - 1), 8'hFF);
        for (int c = CMD_PRERENDER + 1; c <= CMD_LAST_CODE; c++) begin
            send_op(3'(c), 3'($urandom_range(7)), rand_byte());
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            set_mirroring(phase >= PHASE_COUNT / 2);
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 78; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 78; end
                default: begin send_gap_pct = 27; recv_stall_pct = 27; end
            endcase
            first = request_count;
            while (request_count - first < RANDOM_REQUESTS / PHASE_COUNT) begin
                random_burst();
            end
        end

        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* ppu_cpu_register_interface.f */
rtl/pcri_pkg.sv
rtl/pcri_vram.sv
rtl/pcri_oam.sv
rtl/ppu_cpu_register_interface.sv
bench/ppu_reg_file_checker.sv
bench/ppu_cpu_register_interface_tb.sv
